### src/cbm_pkg.sv
// Shared types and codes for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

    localparam int AddrW    = 16;
    localparam int DataW    = 8;
    localparam int PhysW    = 21;
    localparam int RomBankW = 7;
    localparam int RamBankW = 2;

    // Request kinds
    localparam logic [1:0] REQ_CTRL_WR = 2'd0;
    localparam logic [1:0] REQ_ROM_RD  = 2'd1;
    localparam logic [1:0] REQ_RAM_RD  = 2'd2;
    localparam logic [1:0] REQ_RAM_WR  = 2'd3;

    // Mapper kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_BANKED  = 2'd1;
    localparam logic [1:0] KIND_UNSUP   = 2'd2;
    localparam logic [1:0] KIND_UNSUP_X = 2'd3;

    // Targets
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_ROM  = 2'd1;
    localparam logic [1:0] TGT_RAM  = 2'd2;

    // Faults
    localparam logic [1:0] FLT_OK       = 2'd0;
    localparam logic [1:0] FLT_RAM_OFF  = 2'd1;
    localparam logic [1:0] FLT_UNSUP    = 2'd2;
    localparam logic [1:0] FLT_RANGE    = 2'd3;

    // Control write regions, from address bits 14:13
    localparam logic [1:0] RGN_RAM_EN   = 2'd0;
    localparam logic [1:0] RGN_ROM_LOW  = 2'd1;
    localparam logic [1:0] RGN_UPPER    = 2'd2;
    localparam logic [1:0] RGN_MODE     = 2'd3;

    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [2:0] RAM_WINDOW   = 3'b101;   // 0xA000-0xBFFF

    localparam logic [1:0] MAPPER_KIND_RESET = KIND_BANKED;
    localparam logic [RomBankW-1:0] ROM_BANK_RESET = 7'd1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [AddrW-1:0] bus_address;
        logic [DataW-1:0] bus_data;
    } req_t;

    typedef struct packed {
        logic [1:0]       target;
        logic [PhysW-1:0] phys_address;
        logic             write_enable;
        logic [DataW-1:0] write_data;
        logic [1:0]       fault;
    } rsp_t;

    typedef struct packed {
        logic                ram_on;
        logic [RomBankW-1:0] rom_bank;
        logic [RamBankW-1:0] ram_bank;
        logic                upper_to_rom;
    } bank_state_t;

endpackage

`default_nettype wire

### src/cartridge_bank_mapper.sv
// An accepted request passes through the input register and then the result register before result valid.
// Throughput: one request per cycle while rsp_stall is low; the bank registers update in the result stage.
// A result waiting under stall holds the pipe; the input register still fills once.
// Reset: rst_n clears both stages, RAM enable, RAM bank and mode; ROM bank is 1, kind 1.
// Configuration is taken on any cycle cfg_write is high.
`default_nettype none

module cartridge_bank_mapper (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_write,
    input  wire logic [1:0]     cfg_data,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire cbm_pkg::req_t  req_item,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output cbm_pkg::rsp_t       rsp_item
);
    import cbm_pkg::*;

    logic        in_valid_reg;
    req_t        in_item_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_item_reg;
    logic [1:0]  mapper_kind_reg;
    bank_state_t bank_reg;

    rsp_t        rsp_next;
    bank_state_t bank_next;
    logic        advance;
    logic        take;

    // advance the result stage when it is empty or being drained
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = in_valid_reg && !advance;
    assign take      = req_valid && !req_stall;

    cbm_translate u_translate (
        .req         (in_item_reg),
        .mapper_kind (mapper_kind_reg),
        .state       (bank_reg),
        .rsp         (rsp_next),
        .state_next  (bank_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mapper_kind_reg <= MAPPER_KIND_RESET;
        else if (cfg_write)
            mapper_kind_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            bank_reg      <= '{ram_on: 1'b0, rom_bank: ROM_BANK_RESET,
                               ram_bank: '0, upper_to_rom: 1'b0};
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                rsp_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                    bank_reg <= bank_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= req_item;
        if (advance && in_valid_reg)
            rsp_item_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

`ifndef NO_ASSERTIONS
    // a faulted request must not reach memory
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.fault != FLT_OK |->
            rsp_item.target == TGT_NONE && !rsp_item.write_enable
            && rsp_item.phys_address == '0)
    else $error("faulted request drives a memory access");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.write_enable |->
            rsp_item.target == TGT_RAM && bank_reg.ram_on)
    else $error("RAM write issued while RAM disabled or not targeting RAM");

    // low ROM bank field can never hold zero
    assert property (@(posedge clk) disable iff (!rst_n)
        bank_reg.rom_bank[4:0] != 5'd0)
    else $error("ROM bank low field is zero");
`endif

endmodule

`default_nettype wire

### src/cbm_translate.sv
// Decode of one request: address translation, faults and next bank state.
`default_nettype none

module cbm_translate (
    input  wire cbm_pkg::req_t       req,
    input  wire logic [1:0]          mapper_kind,
    input  wire cbm_pkg::bank_state_t state,
    output cbm_pkg::rsp_t            rsp,
    output cbm_pkg::bank_state_t     state_next
);
    import cbm_pkg::*;

    logic             ram_window;
    logic [4:0]       low_bank;
    logic [1:0]       region;

    always_comb
    begin
        ram_window = (req.bus_address[15:13] == RAM_WINDOW);
        region     = req.bus_address[14:13];
        low_bank   = (req.bus_data[4:0] == 5'd0) ? 5'd1 : req.bus_data[4:0];

        rsp        = '0;
        state_next = state;

        case (req.req_type)
            REQ_CTRL_WR:
            begin
                if (req.bus_address[15])
                    rsp.fault = FLT_RANGE;
                else if (mapper_kind inside {KIND_UNSUP, KIND_UNSUP_X})
                    rsp.fault = FLT_UNSUP;
                else if (mapper_kind == KIND_BANKED)
                begin
                    case (region)
                        RGN_RAM_EN:
                            state_next.ram_on = (req.bus_data[3:0] == RAM_EN_KEY);
                        RGN_ROM_LOW:
                            // upper bits survive only in ROM-upper mode
                            state_next.rom_bank = state.upper_to_rom
                                ? {state.rom_bank[6:5], low_bank}
                                : {2'b00, low_bank};
                        RGN_UPPER:
                        begin
                            if (state.upper_to_rom)
                                state_next.rom_bank = {req.bus_data[1:0],
                                                       state.rom_bank[4:0]};
                            else
                                state_next.ram_bank = req.bus_data[1:0];
                        end
                        RGN_MODE:
                        begin
                            state_next.upper_to_rom = req.bus_data[0];
                            if (!req.bus_data[0])
                                state_next.ram_bank = '0;
                        end
                        default: ;
                    endcase
                end
            end
            REQ_ROM_RD:
            begin
                if (req.bus_address[15])
                    rsp.fault = FLT_RANGE;
                else
                begin
                    rsp.target = TGT_ROM;
                    if (req.bus_address[14])
                        rsp.phys_address = {state.rom_bank, req.bus_address[13:0]};
                    else
                        rsp.phys_address = {{(PhysW-AddrW){1'b0}}, req.bus_address};
                end
            end
            default:
            begin
                if (!ram_window)
                    rsp.fault = FLT_RANGE;
                else if (req.req_type == REQ_RAM_WR && !state.ram_on)
                    rsp.fault = FLT_RAM_OFF;
                else
                begin
                    rsp.target       = TGT_RAM;
                    rsp.phys_address = {{(PhysW-RamBankW-13){1'b0}},
                                        state.ram_bank, req.bus_address[12:0]};
                    if (req.req_type == REQ_RAM_WR)
                    begin
                        rsp.write_enable = 1'b1;
                        rsp.write_data   = req.bus_data;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire
